>>> rtl/ogi_pkg.sv
// Shared types and constants for the occupancy grid inflation unit.
// No dependencies; used by every rtl/ogi_* module and the top level.
`timescale 1ns / 1ps

package ogi_pkg;

  localparam int COORD_W = 8;   // cell_x / cell_y width
  localparam int COST_W  = 8;   // stored cost width
  localparam int DIM_W   = 9;   // grid_width / grid_height width
  localparam int RAD_W   = 4;   // inflation radius width
  localparam int OFS_W   = 5;   // signed window offset, -15..15
  localparam int NBR_W   = 10;  // signed neighbor coordinate, -15..270
  localparam int CFG_W   = 9;   // widest configuration register

  typedef enum logic [1:0] {
    REQ_CLEAR = 2'd0,
    REQ_MARK  = 2'd1,
    REQ_READ  = 2'd2,
    REQ_NONE  = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    CFG_GRID_WIDTH      = 2'd0,
    CFG_GRID_HEIGHT     = 2'd1,
    CFG_OBSTACLE_COST   = 2'd2,
    CFG_INFLATION_CELLS = 2'd3
  } cfg_idx_t;

  localparam logic STATUS_OK      = 1'b0;
  localparam logic STATUS_OUTSIDE = 1'b1;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_MARK_RD,
    S_MARK_WR,
    S_CENTER,
    S_SCAN,
    S_DRAIN,
    S_FINISH
  } state_t;

  // Effective configuration, already clamped to the build limits.
  typedef struct packed {
    logic [DIM_W-1:0]  used_w;
    logic [DIM_W-1:0]  used_h;
    logic [COST_W-1:0] obstacle;
    logic [RAD_W-1:0]  radius;
    logic              infl_on;
  } cfg_t;

  // One window candidate per cycle from the scan generator.
  typedef struct packed {
    logic active;     // walking the window
    logic mem_rd;     // candidate in disk and grid, stored in memory
    logic zero_cell;  // candidate in disk and grid, never stored (reads zero)
    logic last;       // final window position
  } scan_t;

endpackage

>>> rtl/ogi_cfg_regs.sv
// Configuration registers of the occupancy grid inflation unit.
// Depends on ogi_pkg; clamps geometry and radius to the build limits.
`timescale 1ns / 1ps

module ogi_cfg_regs #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256,
  parameter int MAX_RADIUS = 15
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic [1:0]                 cfg_index,
  input  logic [ogi_pkg::CFG_W-1:0]  cfg_data,
  output ogi_pkg::cfg_t              cfg
);

  logic [ogi_pkg::DIM_W-1:0]  grid_width;
  logic [ogi_pkg::DIM_W-1:0]  grid_height;
  logic [ogi_pkg::COST_W-1:0] obst_reg;
  logic [ogi_pkg::RAD_W-1:0]  radius_reg;

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_width  <= 9'd256;
      grid_height <= 9'd256;
      obst_reg    <= 8'd254;
      radius_reg  <= 4'd0;
    end else if (cfg_we) begin
      unique case (ogi_pkg::cfg_idx_t'(cfg_index))
        ogi_pkg::CFG_GRID_WIDTH:      grid_width  <= cfg_data;
        ogi_pkg::CFG_GRID_HEIGHT:     grid_height <= cfg_data;
        ogi_pkg::CFG_OBSTACLE_COST:   obst_reg    <= cfg_data[ogi_pkg::COST_W-1:0];
        ogi_pkg::CFG_INFLATION_CELLS: radius_reg  <= cfg_data[ogi_pkg::RAD_W-1:0];
      endcase
    end
  end

  // min() against the limits; the limit only wins when it fits the narrow field
  always_comb begin
    cfg.used_w   = (grid_width < MAX_WIDTH) ? grid_width : ogi_pkg::DIM_W'(MAX_WIDTH);
    cfg.used_h   = (grid_height < MAX_HEIGHT) ? grid_height : ogi_pkg::DIM_W'(MAX_HEIGHT);
    cfg.obstacle = obst_reg;
    cfg.radius   = (radius_reg < MAX_RADIUS) ? radius_reg
                                             : ogi_pkg::RAD_W'(MAX_RADIUS);
    cfg.infl_on  = (radius_reg != 4'd0);
  end

endmodule

>>> rtl/ogi_scan_gen.sv
// Disk window walker: steps (dx, dy) over the square of radius r, one per cycle,
// and flags which positions fall in the disk and the grid. Depends on ogi_pkg.
`timescale 1ns / 1ps

module ogi_scan_gen #(
  parameter int XW = 8,
  parameter int YW = 8
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [ogi_pkg::RAD_W-1:0]     radius,
  input  logic [ogi_pkg::COORD_W-1:0]   cx,
  input  logic [ogi_pkg::COORD_W-1:0]   cy,
  input  logic [ogi_pkg::DIM_W-1:0]     used_w,
  input  logic [ogi_pkg::DIM_W-1:0]     used_h,
  output ogi_pkg::scan_t                scan,
  output logic [XW+YW-1:0]              addr
);

  logic                               active;
  logic signed [ogi_pkg::OFS_W-1:0]   dx, dy, r_s;
  logic signed [ogi_pkg::NBR_W-1:0]   nx, ny;
  logic [ogi_pkg::RAD_W-1:0]          adx, ady;
  logic [7:0]                         sqx, sqy, r2;
  logic [8:0]                         ofs_sq;
  logic                               in_disk, in_geo, in_mem;

  assign r_s = $signed({1'b0, radius});

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
    end else if (start) begin
      active <= 1'b1;
    end else if (active && dx == r_s && dy == r_s) begin
      active <= 1'b0;
    end
  end

  // raster order, dx fastest
  always_ff @(posedge clk) begin
    if (start) begin
      dx <= -r_s;
      dy <= -r_s;
    end else if (active) begin
      if (dx == r_s) begin
        dx <= -r_s;
        dy <= dy + 5'sd1;
      end else begin
        dx <= dx + 5'sd1;
      end
    end
  end

  always_comb begin
    nx   = $signed({2'b00, cx}) + $signed({{(ogi_pkg::NBR_W-ogi_pkg::OFS_W){dx[4]}}, dx});
    ny   = $signed({2'b00, cy}) + $signed({{(ogi_pkg::NBR_W-ogi_pkg::OFS_W){dy[4]}}, dy});
    adx  = dx[4] ? ogi_pkg::RAD_W'(-dx) : dx[ogi_pkg::RAD_W-1:0];
    ady  = dy[4] ? ogi_pkg::RAD_W'(-dy) : dy[ogi_pkg::RAD_W-1:0];
    sqx  = {4'd0, adx} * {4'd0, adx};
    sqy  = {4'd0, ady} * {4'd0, ady};
    r2   = {4'd0, radius} * {4'd0, radius};
    ofs_sq = {1'b0, sqx} + {1'b0, sqy};
    in_disk = (ofs_sq <= {1'b0, r2});
    in_geo  = !nx[ogi_pkg::NBR_W-1] && (nx[8:0] < used_w) &&
              !ny[ogi_pkg::NBR_W-1] && (ny[8:0] < used_h);
    // coordinates above 255 can be in the grid but are never marked
    in_mem  = !nx[8] && !ny[8];

    scan.active    = active;
    scan.mem_rd    = active && in_disk && in_geo && in_mem;
    scan.zero_cell = active && in_disk && in_geo && !in_mem;
    scan.last      = active && dx == r_s && dy == r_s;
    addr           = {ny[YW-1:0], nx[XW-1:0]};
  end

endmodule

>>> rtl/occupancy_grid_inflation_unit.sv
// Top level of the occupancy grid inflation unit: cost grid memory, request
// sequencer and result register. Depends on ogi_pkg, ogi_cfg_regs, ogi_scan_gen.
`timescale 1ns / 1ps

// Keeps an 8-bit cost grid in one single-port-style synchronous RAM (one
// write and one read a cycle, registered read data) and serves one
// transaction at a time. After reset, and for every clear request, a
// clearing pass writes zero to every entry, one per cycle; in_ready stays
// low meanwhile (config writes still land), and a clear request's result
// comes out at the end of the pass. A mark is a read-modify-write of the
// addressed cell. A read fetches the center cell and then, with inflation
// on, walks the (2r+1) x (2r+1) window around it through the RAM read port,
// one position per cycle. Window positions outside the disk or the grid take
// a scan step but no RAM access. The result register lets a new transaction
// start while the last result is still waiting on out_ready. Configuration
// is taken live and must only change while the unit is idle.
module occupancy_grid_inflation_unit #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256,
  parameter int MAX_RADIUS = 15
) (
  input  logic                         clk,
  input  logic                         rst,
  // request channel
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [1:0]                   req_type,
  input  logic [ogi_pkg::COORD_W-1:0]  cell_x,
  input  logic [ogi_pkg::COORD_W-1:0]  cell_y,
  input  logic [ogi_pkg::COST_W-1:0]   cell_value,
  // result channel
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [ogi_pkg::COST_W-1:0]   read_cost,
  output logic                         status,
  // configuration write port
  input  logic                         cfg_we,
  input  logic [1:0]                   cfg_index,
  input  logic [ogi_pkg::CFG_W-1:0]    cfg_data
);

  // Only cells below 256 in each axis are ever marked, so storage covers
  // min(limit, 256) per axis; address is {row, column}.
  localparam int CW    = (MAX_WIDTH  < 256) ? MAX_WIDTH  : 256;
  localparam int CH    = (MAX_HEIGHT < 256) ? MAX_HEIGHT : 256;
  localparam int XW    = (CW > 1) ? $clog2(CW) : 1;
  localparam int YW    = (CH > 1) ? $clog2(CH) : 1;
  localparam int AW    = XW + YW;
  localparam int DEPTH = 1 << AW;

  ogi_pkg::cfg_t   cfg;
  ogi_pkg::scan_t  scan;
  ogi_pkg::state_t state, state_next;

  logic [AW-1:0] scan_addr;
  logic [AW-1:0] ctr_addr;
  logic [AW-1:0] sweep;

  // latched transaction
  ogi_pkg::req_t                 req_q;
  logic [ogi_pkg::COORD_W-1:0]   x_q, y_q;
  logic [ogi_pkg::COST_W-1:0]    val_q;
  logic                          inside_q;
  logic                          clr_result;

  // read pipeline bookkeeping
  logic                          ctr_pend, scan_pend, hit;
  logic [ogi_pkg::COST_W-1:0]    center_cost;

  // memory port controls
  logic                          mem_re, mem_we;
  logic [AW-1:0]                 mem_raddr, mem_waddr;
  logic [ogi_pkg::COST_W-1:0]    mem_wdata, rd_q;
  logic [ogi_pkg::COST_W-1:0]    mem [DEPTH];

  logic                          accept, in_inside, scan_start, load_out;
  logic [ogi_pkg::COST_W-1:0]    half_cost, res_cost;
  logic                          res_status;

  ogi_cfg_regs #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .MAX_RADIUS (MAX_RADIUS)
  ) u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  ogi_scan_gen #(
    .XW (XW),
    .YW (YW)
  ) u_scan (
    .clk    (clk),
    .rst    (rst),
    .start  (scan_start),
    .radius (cfg.radius),
    .cx     (x_q),
    .cy     (y_q),
    .used_w (cfg.used_w),
    .used_h (cfg.used_h),
    .scan   (scan),
    .addr   (scan_addr)
  );

  // ---------------------------------------------------------------- RAM
  // Accesses never overlap on one entry: the sequencer runs one transaction
  // at a time and a mark writes only after its read data is back.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_q <= mem[mem_raddr];
    end
  end

  // ---------------------------------------------------------------- request
  assign accept    = in_valid && in_ready;
  assign in_inside = ({1'b0, cell_x} < cfg.used_w) && ({1'b0, cell_y} < cfg.used_h);
  // inside cells are below min(limit, 256), so the low bits address them
  assign ctr_addr  = {y_q[YW-1:0], x_q[XW-1:0]};

  always_ff @(posedge clk) begin
    if (accept) begin
      req_q    <= ogi_pkg::req_t'(req_type);
      x_q      <= cell_x;
      y_q      <= cell_y;
      val_q    <= cell_value;
      inside_q <= in_inside;
    end
  end

  // ---------------------------------------------------------------- sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ogi_pkg::S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ogi_pkg::S_CLEAR: begin
        if (&sweep) begin
          state_next = clr_result ? ogi_pkg::S_FINISH : ogi_pkg::S_IDLE;
        end
      end
      ogi_pkg::S_IDLE: begin
        if (in_valid) begin
          unique case (ogi_pkg::req_t'(req_type))
            ogi_pkg::REQ_CLEAR: state_next = ogi_pkg::S_CLEAR;
            ogi_pkg::REQ_MARK:  state_next = in_inside ? ogi_pkg::S_MARK_RD
                                                       : ogi_pkg::S_FINISH;
            ogi_pkg::REQ_READ:  state_next = in_inside ? ogi_pkg::S_CENTER
                                                       : ogi_pkg::S_FINISH;
            ogi_pkg::REQ_NONE:  state_next = ogi_pkg::S_FINISH;
          endcase
        end
      end
      ogi_pkg::S_MARK_RD: state_next = ogi_pkg::S_MARK_WR;
      ogi_pkg::S_MARK_WR: state_next = ogi_pkg::S_FINISH;
      ogi_pkg::S_CENTER:  state_next = cfg.infl_on ? ogi_pkg::S_SCAN : ogi_pkg::S_DRAIN;
      ogi_pkg::S_SCAN: begin
        if (scan.last) begin
          state_next = ogi_pkg::S_DRAIN;
        end
      end
      ogi_pkg::S_DRAIN:   state_next = ogi_pkg::S_FINISH;
      ogi_pkg::S_FINISH: begin
        if (!out_valid || out_ready) begin
          state_next = ogi_pkg::S_IDLE;
        end
      end
    endcase
  end

  always_comb begin
    in_ready   = 1'b0;
    mem_re     = 1'b0;
    mem_raddr  = ctr_addr;
    mem_we     = 1'b0;
    mem_waddr  = ctr_addr;
    mem_wdata  = val_q;
    scan_start = 1'b0;
    load_out   = 1'b0;
    unique case (state)
      ogi_pkg::S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = sweep;
        mem_wdata = '0;
      end
      ogi_pkg::S_IDLE:    in_ready = 1'b1;
      ogi_pkg::S_MARK_RD: mem_re = 1'b1;
      ogi_pkg::S_MARK_WR: mem_we = (val_q > rd_q);   // max-merge
      ogi_pkg::S_CENTER: begin
        mem_re     = 1'b1;
        scan_start = cfg.infl_on;
      end
      ogi_pkg::S_SCAN: begin
        mem_re    = scan.mem_rd;
        mem_raddr = scan_addr;
      end
      ogi_pkg::S_DRAIN:   ;
      ogi_pkg::S_FINISH:  load_out = !out_valid || out_ready;
    endcase
  end

  // clearing pass address; wraps back to zero at the end of each pass
  always_ff @(posedge clk) begin
    if (rst) begin
      sweep      <= '0;
      clr_result <= 1'b0;
    end else begin
      if (state == ogi_pkg::S_CLEAR) begin
        sweep <= sweep + 1'b1;
      end
      if (accept) begin
        clr_result <= (ogi_pkg::req_t'(req_type) == ogi_pkg::REQ_CLEAR);
      end
    end
  end

  // ---------------------------------------------------------------- read path
  // RAM read data is registered and shows up in the cycle after the read; tag it by what issued it.
  always_ff @(posedge clk) begin
    if (rst) begin
      ctr_pend  <= 1'b0;
      scan_pend <= 1'b0;
    end else begin
      ctr_pend  <= (state == ogi_pkg::S_CENTER);
      scan_pend <= (state == ogi_pkg::S_SCAN) && scan.mem_rd;
    end
  end

  always_ff @(posedge clk) begin
    if (ctr_pend) begin
      center_cost <= rd_q;
    end
  end

  // obstacle flag; a never-stored cell reads zero, an obstacle only at cost 0
  always_ff @(posedge clk) begin
    if (accept) begin
      hit <= 1'b0;
    end else if ((scan_pend && rd_q >= cfg.obstacle) ||
                 (state == ogi_pkg::S_SCAN && scan.zero_cell && cfg.obstacle == '0)) begin
      hit <= 1'b1;
    end
  end

  // ---------------------------------------------------------------- result
  always_comb begin
    half_cost  = hit ? {1'b0, cfg.obstacle[ogi_pkg::COST_W-1:1]} : '0;
    res_cost   = '0;
    res_status = ogi_pkg::STATUS_OK;
    if (req_q == ogi_pkg::REQ_READ && inside_q) begin
      res_cost = (half_cost > center_cost) ? half_cost : center_cost;
    end
    if ((req_q == ogi_pkg::REQ_MARK || req_q == ogi_pkg::REQ_READ) && !inside_q) begin
      res_status = ogi_pkg::STATUS_OUTSIDE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      read_cost <= res_cost;
      status    <= res_status;
    end
  end

  // ---------------------------------------------------------------- checks
  // grid is written only by the clearing pass or the mark write-back
  a_write_states: assert property (@(posedge clk) disable iff (rst)
    mem_we |-> (state == ogi_pkg::S_CLEAR || state == ogi_pkg::S_MARK_WR))
    else $error("grid write outside clear or mark");

  // window walker runs only while the sequencer is scanning
  a_scan_states: assert property (@(posedge clk) disable iff (rst)
    scan.active |-> state == ogi_pkg::S_SCAN)
    else $error("window scan active outside scan state");

  // only a read produces a nonzero cost
  a_cost_only_read: assert property (@(posedge clk) disable iff (rst)
    load_out && req_q != ogi_pkg::REQ_READ |=> read_cost == '0)
    else $error("nonzero cost for a non-read transaction");

  // one transaction in flight: no back-to-back accepts
  a_single_item: assert property (@(posedge clk) disable iff (rst)
    accept |=> !in_ready)
    else $error("second transaction accepted while busy");

endmodule
